@@ src/insl_pkg.sv @@
// Shared types, codes and sizing constants of the positional insert/remove list.
package insl_pkg;

    localparam int DEFAULT_DEPTH = 16;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_APPEND    = 3'd2,
        CMD_PREPEND   = 3'd3,
        CMD_POP_BACK  = 3'd4,
        CMD_POP_FRONT = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_TAKE_RD,
        S_TAKE_WR,
        S_PULL_RD,
        S_PULL_WR,
        S_DROP,
        S_RESP
    } state_t;

endpackage

@@ src/insl_chan_if.sv @@
// Valid/ready channel interfaces for list commands and list results.
interface insl_cmd_if;
    import insl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface insl_rsp_if;
    import insl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  removed_value;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         count;

    modport source (output valid, output removed_value, output status, output count,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input count,
                    output ready);
endinterface

@@ src/positional_insert_remove_list.sv @@
// Ordered list with indexed insert and remove, stored in a one-read, one-write memory.
//
//  Channel   | Dir | Payload                         | Transfer when
//  ----------+-----+---------------------------------+----------------------
//  request   | in  | cmd, position, value            | valid && ready
//  response  | out | removed_value, status, count    | valid && ready
//
// One command at a time. A failed or unused command is answered in the next cycle.
// An insert at p shifts entries p and above up by one from the tail, then writes the
// value; a removal reads entry p and moves the entries above it down; each moved
// entry costs one memory read and one memory write on the shared port pair.
// Reset empties the list at once; stored values are not cleared.
// A response held by a stalled sink blocks the next request.
module positional_insert_remove_list #(
    parameter int DEPTH = insl_pkg::DEFAULT_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    insl_cmd_if.sink   request,
    insl_rsp_if.source response
);
    import insl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_wdata;

    state_t             state_reg,  state_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [AW-1:0]      ptr_reg,    ptr_next;
    logic [AW-1:0]      pos_reg,    pos_next;
    logic [VALUE_W-1:0] val_reg,    val_next;
    logic [VALUE_W-1:0] got_reg,    got_next;
    status_t            status_reg, status_next;

    logic               accept;
    logic               is_ins;
    logic               is_rem;
    logic [PW-1:0]      dec_pos;
    status_t            dec_status;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      cnt_ext;

    assign accept  = request.valid && request.ready;
    assign pos_ext = PW'(request.position);
    assign cnt_ext = PW'(count_reg);

    // Command decode and range checks; the index check comes before the full check.
    always_comb
    begin
        is_ins     = 1'b0;
        is_rem     = 1'b0;
        dec_pos    = '0;
        dec_status = ST_OK;
        case (request.cmd)
            CMD_INSERT:
            begin
                is_ins  = 1'b1;
                dec_pos = pos_ext;
            end
            CMD_APPEND:
            begin
                is_ins  = 1'b1;
                dec_pos = cnt_ext;
            end
            CMD_PREPEND:
            begin
                is_ins  = 1'b1;
            end
            CMD_REMOVE:
            begin
                is_rem  = 1'b1;
                dec_pos = pos_ext;
            end
            CMD_POP_BACK:
            begin
                is_rem  = 1'b1;
                dec_pos = (cnt_ext == '0) ? '0 : cnt_ext - PW'(1);
            end
            CMD_POP_FRONT:
            begin
                is_rem  = 1'b1;
            end
            default:
            begin
                is_ins  = 1'b0;
            end
        endcase
        if (is_ins)
        begin
            if (dec_pos > cnt_ext)
                dec_status = ST_BAD_INDEX;
            else if (cnt_ext >= PW'(DEPTH))
                dec_status = ST_FULL;
        end
        if (is_rem)
        begin
            if (cnt_ext == '0)
                dec_status = (dec_pos == '0) ? ST_EMPTY : ST_BAD_INDEX;
            else if (dec_pos >= cnt_ext)
                dec_status = ST_BAD_INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        got_reg    <= got_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Sequencer: inserts move entries up from the tail, removals move them down.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        got_next    = got_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg;
        mem_raddr   = ptr_reg;
        mem_wdata   = rd_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next    = AW'(dec_pos);
                    val_next    = request.value;
                    got_next    = '0;
                    status_next = dec_status;
                    ptr_next    = AW'(count_reg);
                    if (dec_status != ST_OK)
                        state_next = S_RESP;
                    else if (is_ins)
                        state_next = (AW'(count_reg) == AW'(dec_pos)) ? S_PUT : S_SHIFT_RD;
                    else if (is_rem)
                        state_next = S_TAKE_RD;
                    else
                        state_next = S_RESP;
                end
            end
            S_SHIFT_RD:
            begin
                mem_raddr  = ptr_reg - AW'(1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                ptr_next   = ptr_reg - AW'(1);
                state_next = ((ptr_reg - AW'(1)) == pos_reg) ? S_PUT : S_SHIFT_RD;
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end
            S_TAKE_RD:
            begin
                mem_raddr  = pos_reg;
                state_next = S_TAKE_WR;
            end
            S_TAKE_WR:
            begin
                got_next   = rd_data_reg;
                ptr_next   = pos_reg;
                state_next = ((CW'(pos_reg) + CW'(1)) == count_reg) ? S_DROP : S_PULL_RD;
            end
            S_PULL_RD:
            begin
                mem_raddr  = ptr_reg + AW'(1);
                state_next = S_PULL_WR;
            end
            S_PULL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                ptr_next   = ptr_reg + AW'(1);
                state_next = ((CW'(ptr_reg) + CW'(2)) == count_reg) ? S_DROP : S_PULL_RD;
            end
            S_DROP:
            begin
                count_next = count_reg - CW'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (response.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign request.ready          = (state_reg == S_IDLE);
    assign response.valid         = (state_reg == S_RESP);
    assign response.removed_value = got_reg;
    assign response.status        = status_reg;
    assign response.count         = COUNT_W'(count_reg);

    // The list never holds more entries than the storage has.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond storage depth");

    // A command is never taken while a result is still on offer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(request.ready && response.valid))
        else $error("request accepted while response pending");

    // A rejected command is answered in the next cycle.
    a_fail_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec_status != ST_OK) |=> response.valid)
        else $error("failed command not answered at once");

    // The count moves by at most one, and only on the way to a response.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg == $past(count_reg) - CW'(1))) && response.valid)
        else $error("entry count changed unexpectedly");

    // A failed command leaves no removed value behind.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.status != ST_OK) |-> (response.removed_value == '0))
        else $error("removed value set on failed command");

endmodule
